/* hdl/pgl_pkg.sv */
// Package for the pad gesture long-press detector.
// Holds the sizing constants, the threshold reset value and the per-pad event type.
// Used by the channel interfaces and by every module of the block.
`default_nettype none

package pgl_pkg;

	localparam int PAD_COUNT = 4;
	localparam int TIME_BITS = 48;
	localparam int THR_BITS  = 24;
	localparam int POT_BITS  = 7;

	localparam logic [THR_BITS-1:0] THR_RESET = THR_BITS'(500000);

	// What one pad reports for one poll.
	typedef struct packed {
		logic press;
		logic nudge;
	} pad_evt_t;

endpackage

`default_nettype wire

/* hdl/pgl_if.sv */
// Channel interfaces of the pad gesture long-press detector: poll, result and
// threshold write. Each carries valid, ready and its payload.
// Depends on pgl_pkg for the field widths.
`default_nettype none

interface pgl_poll_if;
	logic                            valid;
	logic                            ready;
	logic [pgl_pkg::PAD_COUNT-1:0]   pad_held_mask;
	logic                            pot0_moved;
	logic [pgl_pkg::POT_BITS-1:0]    pot0_value;
	logic                            pot1_moved;
	logic [pgl_pkg::POT_BITS-1:0]    pot1_value;
	logic [pgl_pkg::TIME_BITS-1:0]   poll_time;

	modport source (output valid, pad_held_mask, pot0_moved, pot0_value,
		pot1_moved, pot1_value, poll_time, input ready);
	modport sink (input valid, pad_held_mask, pot0_moved, pot0_value,
		pot1_moved, pot1_value, poll_time, output ready);
endinterface

interface pgl_result_if;
	logic                            valid;
	logic                            ready;
	logic                            dial0_set;
	logic [pgl_pkg::POT_BITS-1:0]    dial0_value;
	logic                            dial1_set;
	logic [pgl_pkg::POT_BITS-1:0]    dial1_value;
	logic                            stop_playback;
	logic [pgl_pkg::PAD_COUNT-1:0]   bank_select_mask;
	logic [pgl_pkg::PAD_COUNT-1:0]   nudge_mask;

	modport source (output valid, dial0_set, dial0_value, dial1_set, dial1_value,
		stop_playback, bank_select_mask, nudge_mask, input ready);
	modport sink (input valid, dial0_set, dial0_value, dial1_set, dial1_value,
		stop_playback, bank_select_mask, nudge_mask, output ready);
endinterface

interface pgl_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [pgl_pkg::THR_BITS-1:0]    data;

	modport source (output valid, data, input ready);
	modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* hdl/pgl_pad_track.sv */
// Hold tracker for one touch pad: held flag, press start time and nudge mark.
// Reports the press edge and the long-press nudge for the current poll.
// Depends on pgl_pkg.
`default_nettype none

module pgl_pad_track (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            step,
	input  wire logic                            held,
	input  wire logic                            all_held,
	input  wire logic [pgl_pkg::TIME_BITS-1:0]   now,
	input  wire logic [pgl_pkg::THR_BITS-1:0]    threshold,
	output pgl_pkg::pad_evt_t                    evt
);

	logic                          prev_q;
	logic                          done_q;
	logic [pgl_pkg::TIME_BITS-1:0] start_q;
	logic [pgl_pkg::TIME_BITS-1:0] dur;
	logic                          reached;

	// Hold time wraps with the free-running timestamp.
	assign dur     = now - start_q;
	assign reached = dur >= {{(pgl_pkg::TIME_BITS-pgl_pkg::THR_BITS){1'b0}}, threshold};

	assign evt.press = !all_held && held && !prev_q;
	assign evt.nudge = !all_held && held && prev_q && !done_q && reached;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q  <= 1'b0;
			done_q  <= 1'b0;
			start_q <= '0;
		end else if (step) begin
			if (all_held) begin
				// The panic gesture swallows the hold: no nudge until pressed again.
				prev_q  <= 1'b1;
				done_q  <= 1'b1;
				start_q <= '0;
			end else begin
				prev_q <= held;
				if (held && !prev_q) begin
					start_q <= now;
					done_q  <= 1'b0;
				end else if (held && !done_q) begin
					if (reached) begin
						done_q <= 1'b1;
					end
				end else if (!held && prev_q) begin
					start_q <= '0;
					done_q  <= 1'b0;
				end
			end
		end
	end

	a_nudge_once: assert property (@(posedge clk) disable iff (!arst_n)
		(step && evt.nudge) |=> done_q)
		else $error("nudge fired without marking the hold done");

	a_press_not_nudge: assert property (@(posedge clk) disable iff (!arst_n)
		!(evt.press && evt.nudge))
		else $error("press edge and nudge on the same poll");

	a_panic_marks: assert property (@(posedge clk) disable iff (!arst_n)
		(step && all_held) |=> (prev_q && done_q && start_q == '0))
		else $error("all-held poll did not consume the hold");

endmodule

`default_nettype wire

/* hdl/pad_gesture_long_press_detector_unit.sv */
// Pad gesture long-press detector. Takes one poll word per cycle and returns one result
// word per poll, in the cycle after acceptance, from a single result register. Poll ready
// drops only while a result waits and is not taken in that cycle, so with the result
// side ready the rate is one poll per clock; the path that sets the clock is the per-pad
// 48-bit hold-time subtraction and threshold compare. Threshold writes are always taken.
`default_nettype none

module pad_gesture_long_press_detector_unit (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pgl_poll_if.sink   poll,
	pgl_result_if.source result,
	pgl_cfg_if.sink    cfg
);

	logic [pgl_pkg::THR_BITS-1:0]  thr_q;
	logic                          latched_q;
	logic                          out_valid_q;
	logic                          dial0_set_q;
	logic [pgl_pkg::POT_BITS-1:0]  dial0_value_q;
	logic                          dial1_set_q;
	logic [pgl_pkg::POT_BITS-1:0]  dial1_value_q;
	logic                          stop_q;
	logic [pgl_pkg::PAD_COUNT-1:0] bank_q;
	logic [pgl_pkg::PAD_COUNT-1:0] nudge_q;

	logic                          accept;
	logic                          all_held;
	logic [pgl_pkg::PAD_COUNT-1:0] press_vec;
	logic [pgl_pkg::PAD_COUNT-1:0] nudge_vec;
	pgl_pkg::pad_evt_t             evt [pgl_pkg::PAD_COUNT];

	assign cfg.ready  = 1'b1;
	assign poll.ready = !out_valid_q || result.ready;
	assign accept     = poll.valid && poll.ready;
	assign all_held   = &poll.pad_held_mask;

	for (genvar i = 0; i < pgl_pkg::PAD_COUNT; i++) begin : g_pad
		pgl_pad_track u_pad (
			.clk       (clk),
			.arst_n    (arst_n),
			.step      (accept),
			.held      (poll.pad_held_mask[i]),
			.all_held  (all_held),
			.now       (poll.poll_time),
			.threshold (thr_q),
			.evt       (evt[i])
		);
		assign press_vec[i] = evt[i].press;
		assign nudge_vec[i] = evt[i].nudge;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= pgl_pkg::THR_RESET;
		end else if (cfg.valid && cfg.ready) begin
			thr_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_q   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				latched_q <= all_held;
			end
			if (accept) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			dial0_set_q   <= poll.pot0_moved;
			dial0_value_q <= poll.pot0_moved ? poll.pot0_value : '0;
			dial1_set_q   <= poll.pot1_moved;
			dial1_value_q <= poll.pot1_moved ? poll.pot1_value : '0;
			stop_q        <= all_held && !latched_q;
			bank_q        <= press_vec;
			nudge_q       <= nudge_vec;
		end
	end

	assign result.valid            = out_valid_q;
	assign result.dial0_set        = dial0_set_q;
	assign result.dial0_value      = dial0_value_q;
	assign result.dial1_set        = dial1_set_q;
	assign result.dial1_value      = dial1_value_q;
	assign result.stop_playback    = stop_q;
	assign result.bank_select_mask = bank_q;
	assign result.nudge_mask       = nudge_q;

	a_stop_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && stop_q) |-> (bank_q == '0 && nudge_q == '0))
		else $error("stop word carries pad events");

	a_stop_once: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && all_held) |=> latched_q)
		else $error("stop not latched after an all-held poll");

	a_dial_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !dial0_set_q) |-> (dial0_value_q == '0))
		else $error("dial 0 value without set");

	a_disjoint: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> ((bank_q & nudge_q) == '0))
		else $error("pad reports press and nudge in one word");

endmodule

`default_nettype wire

/* sim/pad_gesture_long_press_detector_unit_tb.sv */
`timescale 1ns / 1ps
// Testbench for the pad gesture long-press detector: a directed table, then random
// gesture sequences under several hold thresholds, checked against a local pad model.
// Depends on pgl_pkg, the channel interfaces in pgl_if and the detector top level.

module pad_gesture_long_press_detector_unit_tb;

	localparam int PAD_COUNT = pgl_pkg::PAD_COUNT;
	localparam int TIME_BITS = pgl_pkg::TIME_BITS;
	localparam int THR_BITS  = pgl_pkg::THR_BITS;
	localparam int POT_BITS  = pgl_pkg::POT_BITS;

	localparam int CYCLE_LIMIT = 200000;
	localparam int PHASE_POLLS = 330;
	localparam int DRAIN_CYCLES = 6;

	typedef struct packed {
		logic                 dial0_set;
		logic [POT_BITS-1:0]  dial0_value;
		logic                 dial1_set;
		logic [POT_BITS-1:0]  dial1_value;
		logic                 stop_playback;
		logic [PAD_COUNT-1:0] bank_select_mask;
		logic [PAD_COUNT-1:0] nudge_mask;
	} pad_result_t;

	// One poll word, with an optional hand-written result for the directed rows.
	typedef struct packed {
		logic [PAD_COUNT-1:0] held;
		logic                 pot0_moved;
		logic [POT_BITS-1:0]  pot0_value;
		logic                 pot1_moved;
		logic [POT_BITS-1:0]  pot1_value;
		logic [TIME_BITS-1:0] stamp;
		logic                 typed;
		pad_result_t          want;
	} poll_item_t;

	localparam pad_result_t NO_RES = '0;

	localparam poll_item_t DIRECTED [24] = '{
		'{4'h0, 1'b0, 7'd0, 1'b0, 7'd0, 48'd0, 1'b1, NO_RES},
		'{4'h1, 1'b1, 7'd127, 1'b1, 7'd127, 48'd10, 1'b1,
			'{1'b1, 7'd127, 1'b1, 7'd127, 1'b0, 4'h1, 4'h0}},
		'{4'h1, 1'b0, 7'd127, 1'b0, 7'd127, 48'd500009, 1'b1, NO_RES},
		'{4'h1, 1'b0, 7'd0, 1'b0, 7'd0, 48'd500010, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 4'h0, 4'h1}},
		'{4'h1, 1'b0, 7'd0, 1'b0, 7'd0, 48'd600000, 1'b1, NO_RES},
		'{4'h0, 1'b0, 7'd0, 1'b0, 7'd0, 48'd600001, 1'b1, NO_RES},
		'{4'hF, 1'b0, 7'd0, 1'b0, 7'd0, 48'd700000, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b1, 4'h0, 4'h0}},
		'{4'hF, 1'b0, 7'd0, 1'b0, 7'd0, 48'd700001, 1'b1, NO_RES},
		'{4'h7, 1'b0, 7'd0, 1'b0, 7'd0, 48'd5000000, 1'b1, NO_RES},
		'{4'hF, 1'b0, 7'd0, 1'b0, 7'd0, 48'd5000001, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b1, 4'h0, 4'h0}},
		'{4'h0, 1'b0, 7'd0, 1'b0, 7'd0, 48'd5000002, 1'b1, NO_RES},
		'{4'hA, 1'b0, 7'd0, 1'b0, 7'd0, 48'd5000003, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 4'hA, 4'h0}},
		'{4'hE, 1'b0, 7'd0, 1'b0, 7'd0, 48'd5000004, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 4'h4, 4'h0}},
		'{4'hE, 1'b0, 7'd0, 1'b0, 7'd0, 48'd5500003, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 4'h0, 4'hA}},
		'{4'h0, 1'b0, 7'd0, 1'b0, 7'd0, 48'd5500004, 1'b1, NO_RES},
		'{4'h8, 1'b0, 7'd0, 1'b0, 7'd0, 48'hFFFF_FFFF_FFFF, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 4'h8, 4'h0}},
		'{4'h8, 1'b0, 7'd0, 1'b0, 7'd0, 48'd499998, 1'b1, NO_RES},
		'{4'h8, 1'b0, 7'd0, 1'b0, 7'd0, 48'd499999, 1'b1,
			'{1'b0, 7'd0, 1'b0, 7'd0, 1'b0, 4'h0, 4'h8}},
		'{4'h0, 1'b1, 7'd0, 1'b0, 7'd127, 48'd500000, 1'b1,
			'{1'b1, 7'd0, 1'b0, 7'd0, 1'b0, 4'h0, 4'h0}},
		'{4'h0, 1'b0, 7'd127, 1'b1, 7'd0, 48'd500001, 1'b1,
			'{1'b0, 7'd0, 1'b1, 7'd0, 1'b0, 4'h0, 4'h0}},
		'{4'hF, 1'b1, 7'd42, 1'b1, 7'd85, 48'd123, 1'b0, NO_RES},
		'{4'h5, 1'b0, 7'd0, 1'b0, 7'd0, 48'hAAAA_AAAA_AAAA, 1'b0, NO_RES},
		'{4'h0, 1'b0, 7'd0, 1'b0, 7'd0, 48'h5555_5555_5555, 1'b0, NO_RES},
		'{4'h5, 1'b0, 7'd0, 1'b0, 7'd0, 48'h5555_5555_5556, 1'b0, NO_RES}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	pgl_poll_if   poll_ch ();
	pgl_result_if res_ch ();
	pgl_cfg_if    cfg_ch ();

	pad_gesture_long_press_detector_unit DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.poll   (poll_ch),
		.result (res_ch),
		.cfg    (cfg_ch)
	);

	always #5 clk = ~clk;

	// Local copy of the detector state and its threshold.
	logic [THR_BITS-1:0]  thr_now;
	logic                 prev_held [PAD_COUNT];
	logic [TIME_BITS-1:0] hold_start [PAD_COUNT];
	logic                 nudge_fired [PAD_COUNT];
	logic                 stop_latched;

	poll_item_t  polls_pending [$];
	pad_result_t results_due [$];
	poll_item_t  tx_cur;
	int          tx_gap;
	int          rx_stall;
	logic        rx_hold;
	logic        no_idle;

	int errors = 0;
	int cycles = 0;
	int polls_in = 0;
	int results_checked = 0;
	int stops_seen = 0;
	int banks_seen = 0;
	int nudges_seen = 0;
	int thr_writes = 0;

	function automatic pad_result_t step_pads(poll_item_t it);
		pad_result_t r;
		logic [TIME_BITS-1:0] held_for;
		r = '0;
		r.dial0_set = it.pot0_moved;
		r.dial0_value = it.pot0_moved ? it.pot0_value : '0;
		r.dial1_set = it.pot1_moved;
		r.dial1_value = it.pot1_moved ? it.pot1_value : '0;
		if (it.held == '1) begin
			// The all-pads gesture swallows edges and marks every hold as already nudged.
			if (!stop_latched) begin
				stop_latched = 1'b1;
				r.stop_playback = 1'b1;
			end
			for (int i = 0; i < PAD_COUNT; i++) begin
				prev_held[i] = 1'b1;
				hold_start[i] = '0;
				nudge_fired[i] = 1'b1;
			end
		end else begin
			stop_latched = 1'b0;
			for (int i = 0; i < PAD_COUNT; i++) begin
				if (it.held[i] && !prev_held[i]) begin
					hold_start[i] = it.stamp;
					nudge_fired[i] = 1'b0;
					r.bank_select_mask[i] = 1'b1;
				end else if (it.held[i] && !nudge_fired[i]) begin
					held_for = it.stamp - hold_start[i];
					if (held_for >= TIME_BITS'(thr_now)) begin
						nudge_fired[i] = 1'b1;
						r.nudge_mask[i] = 1'b1;
					end
				end else if (!it.held[i] && prev_held[i]) begin
					hold_start[i] = '0;
					nudge_fired[i] = 1'b0;
				end
				prev_held[i] = it.held[i];
			end
		end
		return r;
	endfunction

	function automatic void check_field(string name, int unsigned want, int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			errors++;
		end
	endfunction

	// Poll sender with random gaps between words.
	always @(posedge clk) begin
		poll_item_t nxt;
		if (!arst_n) begin
			poll_ch.valid <= 1'b0;
		end else if (!poll_ch.valid || poll_ch.ready) begin
			if (tx_gap > 0) begin
				tx_gap <= tx_gap - 1;
				poll_ch.valid <= 1'b0;
			end else if (polls_pending.size() != 0) begin
				nxt = polls_pending.pop_front();
				tx_cur <= nxt;
				poll_ch.valid <= 1'b1;
				poll_ch.pad_held_mask <= nxt.held;
				poll_ch.pot0_moved <= nxt.pot0_moved;
				poll_ch.pot0_value <= nxt.pot0_value;
				poll_ch.pot1_moved <= nxt.pot1_moved;
				poll_ch.pot1_value <= nxt.pot1_value;
				poll_ch.poll_time <= nxt.stamp;
				if (!no_idle && $urandom_range(0, 7) == 0)
					tx_gap <= $urandom_range(1, 10);
			end else begin
				poll_ch.valid <= 1'b0;
			end
		end
	end

	// Result receiver: short random stalls, plus the long hold-off below.
	always @(posedge clk) begin
		if (!arst_n) begin
			res_ch.ready <= 1'b0;
		end else if (rx_hold) begin
			res_ch.ready <= 1'b0;
		end else if (rx_stall > 0) begin
			rx_stall <= rx_stall - 1;
			res_ch.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 9) == 0) begin
			rx_stall <= $urandom_range(0, 9);
			res_ch.ready <= 1'b0;
		end else begin
			res_ch.ready <= 1'b1;
		end
	end

	// Hold the result side off long enough that the poll side must back up.
	initial begin
		rx_hold = 1'b0;
		wait (polls_in >= 700);
		@(posedge clk);
		rx_hold <= 1'b1;
		repeat (300) @(posedge clk);
		rx_hold <= 1'b0;
	end

	// Accepted polls and threshold writes feed the local model.
	always @(posedge clk) begin
		pad_result_t p;
		if (arst_n && cfg_ch.valid && cfg_ch.ready) begin
			thr_now = cfg_ch.data;
			thr_writes++;
		end
		if (arst_n && poll_ch.valid && poll_ch.ready) begin
			p = step_pads(tx_cur);
			results_due.push_back(tx_cur.typed ? tx_cur.want : p);
			polls_in++;
			stops_seen += p.stop_playback;
			banks_seen += $countones(p.bank_select_mask);
			nudges_seen += $countones(p.nudge_mask);
		end
	end

	always @(posedge clk) begin
		pad_result_t want;
		if (arst_n && res_ch.valid && res_ch.ready) begin
			if (results_due.size() == 0) begin
				$display("%0t: result word with nothing expected", $time);
				errors++;
			end else begin
				want = results_due.pop_front();
				results_checked++;
				check_field("dial0_set", want.dial0_set, res_ch.dial0_set);
				check_field("dial0_value", want.dial0_value, res_ch.dial0_value);
				check_field("dial1_set", want.dial1_set, res_ch.dial1_set);
				check_field("dial1_value", want.dial1_value, res_ch.dial1_value);
				check_field("stop_playback", want.stop_playback, res_ch.stop_playback);
				check_field("bank_select_mask", want.bank_select_mask,
					res_ch.bank_select_mask);
				check_field("nudge_mask", want.nudge_mask, res_ch.nudge_mask);
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles", $time, cycles);
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic wait_drained();
		do @(posedge clk);
		while (polls_pending.size() != 0 || poll_ch.valid || results_due.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_threshold(logic [THR_BITS-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk);
		while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
	endtask

	// Pads come and go a few at a time so holds run long enough to reach the
	// threshold; now and then all four close together, or the word is scrambled.
	task automatic queue_gestures(int unsigned thr, int count);
		logic [PAD_COUNT-1:0] held;
		logic [TIME_BITS-1:0] stamp;
		int all_left;
		poll_item_t it;
		held = '0;
		all_left = 0;
		stamp = TIME_BITS'({$urandom(), $urandom()});
		if ($urandom_range(0, 2) == 0)
			stamp = '1 - TIME_BITS'($urandom_range(0, 4 * thr + 8));
		repeat (count) begin
			if (all_left > 0) begin
				held = '1;
				all_left--;
			end else if ($urandom_range(0, 23) == 0) begin
				held = '1;
				all_left = $urandom_range(0, 2);
			end else if ($urandom_range(0, 15) == 0) begin
				held = PAD_COUNT'($urandom());
			end else begin
				for (int i = 0; i < PAD_COUNT; i++)
					if ($urandom_range(0, 7) == 0)
						held[i] = ~held[i];
			end
			if ($urandom_range(0, 31) == 0)
				stamp = TIME_BITS'({$urandom(), $urandom()});
			else
				stamp = stamp + TIME_BITS'($urandom_range(0, thr / 4 + 1));
			it = '0;
			it.held = held;
			it.pot0_moved = $urandom_range(0, 1);
			it.pot0_value = POT_BITS'($urandom());
			it.pot1_moved = $urandom_range(0, 1);
			it.pot1_value = POT_BITS'($urandom());
			it.stamp = stamp;
			polls_pending.push_back(it);
		end
	endtask

	initial begin
		int unsigned thr_plan [6];
		poll_ch.valid = 1'b0;
		poll_ch.pad_held_mask = '0;
		poll_ch.pot0_moved = 1'b0;
		poll_ch.pot0_value = '0;
		poll_ch.pot1_moved = 1'b0;
		poll_ch.pot1_value = '0;
		poll_ch.poll_time = '0;
		res_ch.ready = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		tx_cur = '0;
		tx_gap = 0;
		rx_stall = 0;
		no_idle = 1'b0;
		thr_now = pgl_pkg::THR_RESET;
		stop_latched = 1'b0;
		for (int i = 0; i < PAD_COUNT; i++) begin
			prev_held[i] = 1'b0;
			hold_start[i] = '0;
			nudge_fired[i] = 1'b0;
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		foreach (DIRECTED[i])
			polls_pending.push_back(DIRECTED[i]);
		wait_drained();

		thr_plan = '{1, 16777215, 37, $urandom_range(100, 5000), 500000, 3};
		foreach (thr_plan[k]) begin
			write_threshold(THR_BITS'(thr_plan[k]));
			// The last phase runs with both sides always ready.
			if (k == 5)
				no_idle = 1'b1;
			queue_gestures(thr_plan[k], PHASE_POLLS);
			wait_drained();
		end

		if (results_due.size() != 0) begin
			$display("%0t: %0d expected results never arrived", $time, results_due.size());
			errors++;
		end
		$display("Ran %0d polls over %0d threshold settings; %0d result words checked.",
			polls_in, thr_writes + 1, results_checked);
		$display("Seen: %0d stop pulses, %0d bank selects, %0d nudges.",
			stops_seen, banks_seen, nudges_seen);
		if (errors == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
